### hdl/bmx_pkg.sv
`default_nettype none

package bmx_pkg;

  localparam int LIMB_W         = 64;
  localparam int OPERAND_WORDS  = 4;
  localparam int EXPONENT_WORDS = 4;
  localparam int OP_W           = LIMB_W * OPERAND_WORDS;
  localparam int EXP_W          = LIMB_W * EXPONENT_WORDS;
  localparam int OPC_W          = 2;
  localparam int WIDX_W         = 2;
  localparam int CNT_W          = $clog2(OP_W);
  localparam int POS_W          = $clog2(EXP_W) + 1;

  localparam logic [OPC_W-1:0] OPC_BASE = 2'd0;
  localparam logic [OPC_W-1:0] OPC_EXP  = 2'd1;
  localparam logic [OPC_W-1:0] OPC_MOD  = 2'd2;

  typedef struct packed {
    logic clr;
    logic add;
    logic sub1;
    logic sub2;
  } bmx_cell_ctrl_t;

  typedef struct packed {
    logic clr;
    logic add;
    logic red;
  } bmx_chain_op_t;

endpackage

`default_nettype wire

### hdl/bmx_if.sv
`default_nettype none

interface bmx_cmd_if import bmx_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [OPC_W-1:0]    opcode;
  logic [WIDX_W-1:0]   word_index;
  logic [LIMB_W-1:0]   word_data;
  logic                start_req;

  modport source (output valid, opcode, word_index, word_data, start_req, input ready);
  modport sink (input valid, opcode, word_index, word_data, start_req, output ready);
endinterface

interface bmx_res_if import bmx_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [WIDX_W-1:0]   out_index;
  logic [LIMB_W-1:0]   out_data;
  logic                last;

  modport source (output valid, out_index, out_data, last, input ready);
  modport sink (input valid, out_index, out_data, last, output ready);
endinterface

`default_nettype wire

### hdl/bignum_modular_exponentiator.sv
`default_nettype none

// channel  role    payload
// cmd      sink    opcode, word_index, word_data, start_req
// res      source  out_index, out_data, last
//
// a start runs up to 513 modular multiplies, each an add step and a reduce
// step per multiplier bit in the limb cell row,
// then offers the four result words; cmd is not ready until the last is taken.
// rst is synchronous; operand stores hold no reset value.
// res holds its word while ready is low.

module bignum_modular_exponentiator import bmx_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  bmx_cmd_if.sink      cmd,
  bmx_res_if.source    res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHKM   = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_ADD    = 3'd3;
  localparam logic [2:0] S_RED    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;
  localparam logic [2:0] S_DECIDE = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  localparam logic [1:0] K_RED = 2'd0;
  localparam logic [1:0] K_MUL = 2'd1;
  localparam logic [1:0] K_SQR = 2'd2;

  localparam logic [WIDX_W-1:0] LAST_IDX = WIDX_W'(OPERAND_WORDS - 1);

  logic [2:0]        state;
  logic [1:0]        kind;
  logic [CNT_W-1:0]  cnt;
  logic [POS_W-1:0]  pos;
  logic [WIDX_W-1:0] oidx;

  logic [OP_W-1:0]   base;
  logic [OP_W-1:0]   modulus;
  logic [EXP_W-1:0]  expo;
  logic [OP_W-1:0]   acc;
  logic [OP_W-1:0]   a_sh;
  logic [OP_W-1:0]   r;
  logic [OP_W-1:0]   b_op;
  logic [WIDX_W-1:0] woff;
  logic [WIDX_W-1:0] ooff;
  bmx_chain_op_t     op;
  logic              in_fire;

  assign in_fire = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign woff = LAST_IDX - cmd.word_index;
  assign ooff = LAST_IDX - oidx;

  assign res.valid     = (state == S_OUT);
  assign res.out_index = oidx;
  assign res.out_data  = acc[ooff*LIMB_W +: LIMB_W];
  assign res.last      = (oidx == LAST_IDX);

  assign b_op = (kind == K_RED) ? acc : base;

  always_comb begin
    op.clr = (state == S_SETUP);
    op.add = (state == S_ADD);
    op.red = (state == S_RED);
  end

  bmx_chain u_chain (
    .clk     (clk),
    .op      (op),
    .add_bit (a_sh[OP_W-1]),
    .b       (b_op),
    .m       (modulus),
    .r       (r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= K_RED;
      cnt   <= '0;
      pos   <= '0;
      oidx  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire && cmd.start_req) begin
            state <= S_CHKM;
            oidx  <= '0;
          end
        end
        S_CHKM: begin
          kind  <= K_RED;
          state <= (modulus == '0) ? S_OUT : S_SETUP;
        end
        S_SETUP: begin
          cnt   <= '0;
          state <= S_ADD;
        end
        S_ADD: begin
          state <= S_RED;
        end
        S_RED: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(OP_W - 1)) begin
            state <= S_DONE;
          end else begin
            state <= S_ADD;
          end
        end
        S_DONE: begin
          case (kind)
            K_RED: begin
              pos   <= '0;
              state <= S_DECIDE;
            end
            K_MUL: begin
              kind  <= K_SQR;
              state <= S_SETUP;
            end
            default: begin
              if (pos == POS_W'(EXP_W - 1)) begin
                pos   <= '0;
                state <= S_OUT;
              end else begin
                pos   <= pos + 1'b1;
                state <= S_DECIDE;
              end
            end
          endcase
        end
        S_DECIDE: begin
          kind  <= expo[pos[POS_W-2:0]] ? K_MUL : K_SQR;
          state <= S_SETUP;
        end
        S_OUT: begin
          if (res.ready) begin
            oidx <= oidx + 1'b1;
            if (oidx == LAST_IDX) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      case (cmd.opcode)
        OPC_BASE: base[woff*LIMB_W +: LIMB_W]    <= cmd.word_data;
        OPC_EXP:  expo[woff*LIMB_W +: LIMB_W]    <= cmd.word_data;
        OPC_MOD:  modulus[woff*LIMB_W +: LIMB_W] <= cmd.word_data;
        default: ;
      endcase
    end
    if (state == S_CHKM) begin
      if (modulus == '0 || modulus == OP_W'(1)) begin
        acc <= '0;
      end else begin
        acc <= OP_W'(1);
      end
    end
    if (state == S_SETUP) begin
      a_sh <= (kind == K_MUL) ? acc : base;
    end
    if (state == S_RED) begin
      a_sh <= {a_sh[OP_W-2:0], 1'b0};
    end
    if (state == S_DONE) begin
      if (kind == K_MUL) begin
        acc <= r;
      end else begin
        base <= r;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/bmx_cell.sv
`default_nettype none

module bmx_cell import bmx_pkg::*; (
  input  logic                clk,
  input  bmx_cell_ctrl_t      ctrl,
  input  logic [LIMB_W-1:0]   b,
  input  logic [LIMB_W-1:0]   m,
  input  logic                r_shin,
  input  logic                m_shin,
  input  logic                add_bit,
  input  logic                cin,
  input  logic                bin1,
  input  logic                bin2,
  output logic [LIMB_W-1:0]   r,
  output logic                cout,
  output logic                bout1,
  output logic                bout2
);

  logic [LIMB_W:0] sum;
  logic [LIMB_W:0] dif1;
  logic [LIMB_W:0] dif2;

  always_comb begin
    sum  = {1'b0, r[LIMB_W-2:0], r_shin} + {1'b0, (add_bit ? b : {LIMB_W{1'b0}})}
           + {{LIMB_W{1'b0}}, cin};
    dif1 = {1'b0, r} - {1'b0, m} - {{LIMB_W{1'b0}}, bin1};
    dif2 = {1'b0, r} - {1'b0, m[LIMB_W-2:0], m_shin} - {{LIMB_W{1'b0}}, bin2};
  end

  assign cout  = sum[LIMB_W];
  assign bout1 = dif1[LIMB_W];
  assign bout2 = dif2[LIMB_W];

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      r <= '0;
    end else if (ctrl.add) begin
      r <= sum[LIMB_W-1:0];
    end else if (ctrl.sub2) begin
      r <= dif2[LIMB_W-1:0];
    end else if (ctrl.sub1) begin
      r <= dif1[LIMB_W-1:0];
    end
  end

endmodule

`default_nettype wire

### hdl/bmx_chain.sv
`default_nettype none

module bmx_chain import bmx_pkg::*; (
  input  logic              clk,
  input  bmx_chain_op_t     op,
  input  logic              add_bit,
  input  logic [OP_W-1:0]   b,
  input  logic [OP_W-1:0]   m,
  output logic [OP_W-1:0]   r
);

  localparam int N = OPERAND_WORDS;

  logic [LIMB_W-1:0] r_w [N];
  logic [N-1:0]      co;
  logic [N-1:0]      bo1;
  logic [N-1:0]      bo2;
  logic [1:0]        ext;
  logic [2:0]        hi2;
  logic              ok1;
  logic              ok2;
  bmx_cell_ctrl_t    cctrl;

  // value under reduction is ext * 2^OP_W + r, below three times the modulus
  always_comb begin
    hi2   = {1'b0, ext} - {2'b0, m[OP_W-1]} - {2'b0, bo2[N-1]};
    ok2   = !hi2[2];
    ok1   = !((ext == 2'd0) && bo1[N-1]);
    cctrl.clr  = op.clr;
    cctrl.add  = op.add;
    cctrl.sub2 = op.red && ok2;
    cctrl.sub1 = op.red && ok1 && !ok2;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic r_shin;
    logic m_shin;
    logic cin;
    logic bin1;
    logic bin2;

    if (i == 0) begin : g_first
      assign r_shin = 1'b0;
      assign m_shin = 1'b0;
      assign cin    = 1'b0;
      assign bin1   = 1'b0;
      assign bin2   = 1'b0;
    end else begin : g_rest
      assign r_shin = r_w[i-1][LIMB_W-1];
      assign m_shin = m[i*LIMB_W-1];
      assign cin    = co[i-1];
      assign bin1   = bo1[i-1];
      assign bin2   = bo2[i-1];
    end

    bmx_cell u_cell (
      .clk     (clk),
      .ctrl    (cctrl),
      .b       (b[i*LIMB_W +: LIMB_W]),
      .m       (m[i*LIMB_W +: LIMB_W]),
      .r_shin  (r_shin),
      .m_shin  (m_shin),
      .add_bit (add_bit),
      .cin     (cin),
      .bin1    (bin1),
      .bin2    (bin2),
      .r       (r_w[i]),
      .cout    (co[i]),
      .bout1   (bo1[i]),
      .bout2   (bo2[i])
    );

    assign r[i*LIMB_W +: LIMB_W] = r_w[i];
  end

  always_ff @(posedge clk) begin
    if (op.clr || op.red) begin
      ext <= 2'd0;
    end else if (op.add) begin
      ext <= {1'b0, r_w[N-1][LIMB_W-1]} + {1'b0, co[N-1]};
    end
  end

endmodule

`default_nettype wire

### hdl/bmx_checker.sv
`default_nettype none

module bmx_checker import bmx_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cmd_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic              res_last,
  input logic [WIDX_W-1:0] res_out_index
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd_ready && res_valid))
    else $error("command taken while result pending");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last |=>
      res_valid && (res_out_index == $past(res_out_index) + 1'b1))
    else $error("result words out of sequence");

  a_end_burst: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_last |=> !res_valid && cmd_ready)
    else $error("no return to idle after last word");

endmodule

bind bignum_modular_exponentiator bmx_checker u_bmx_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_ready     (cmd.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_last      (res.last),
  .res_out_index (res.out_index)
);

`default_nettype wire
